// ===== rtl/tlf_pkg.sv =====
// ----------------------------------------------------------------------------
// tlf_pkg
// Shared types, constants and helpers for the text line folder.
// ----------------------------------------------------------------------------
`default_nettype none

package tlf_pkg;

  localparam int LW_W         = 6;
  localparam int BYTE_W       = 8;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 6;

  localparam logic [BYTE_W-1:0]      NEWLINE_BYTE   = 8'h0A;
  localparam logic [BYTE_W-1:0]      SPACE_BYTE     = 8'h20;
  localparam logic [BYTE_W-1:0]      TAB_BYTE       = 8'h09;
  localparam logic [BYTE_W-1:0]      CR_BYTE        = 8'h0D;
  localparam logic [LW_W-1:0]        LINE_WIDTH_RST = 6'd32;

  localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BREAK_AT_SPACE = 1'd1;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic take;
    logic rd;
    logic ld_byte;
    logic ld_nl;
  } tlf_cmd_t;

  typedef struct packed {
    logic flush;
    logic brk;
    logic fill_zero;
    logic in_nl;
    logic out_free;
    logic cnt_one;
    logic item_nl;
  } tlf_status_t;

  function automatic logic is_blank(input logic [BYTE_W-1:0] b);
    return (b == SPACE_BYTE) || ((b >= TAB_BYTE) && (b <= CR_BYTE));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tlf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlf_ctrl
// Sequencer: accepts an item, steps the segment reads and result loads.
// ----------------------------------------------------------------------------
`default_nettype none

module tlf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tlf_pkg::tlf_status_t st,
  output tlf_pkg::tlf_cmd_t        cmd
);
  import tlf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_NL   = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd.take    = 1'b0;
    cmd.rd      = 1'b0;
    cmd.ld_byte = 1'b0;
    cmd.ld_nl   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (st.flush) begin
            if (!st.fill_zero) begin
              state_next = ST_READ;
            end else if (st.in_nl) begin
              state_next = ST_NL;
            end
          end else if (st.brk) begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (st.out_free) begin
          cmd.ld_byte = 1'b1;
          if (st.cnt_one) begin
            state_next = st.item_nl ? ST_NL : ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_NL: begin
        if (st.out_free) begin
          cmd.ld_nl  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tlf_datapath.sv =====
// ----------------------------------------------------------------------------
// tlf_datapath
// Segment ring buffer, fill and break tracking, config and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlf_datapath #(
  parameter int MAX_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [tlf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tlf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            op,
  input  wire logic [tlf_pkg::BYTE_W-1:0]      in_byte,
  input  wire tlf_pkg::tlf_cmd_t               cmd,
  output tlf_pkg::tlf_status_t                 st,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [tlf_pkg::BYTE_W-1:0]           out_byte,
  output logic                                 run_end
);
  import tlf_pkg::*;

  localparam int FILL_W = $clog2(MAX_WIDTH + 1);
  localparam int PTR_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SUM_W  = FILL_W + 1;
  localparam int CMP_W  = LW_W + 1;

  logic [BYTE_W-1:0] mem [MAX_WIDTH];

  logic [LW_W-1:0]   line_width;
  logic              break_at_space;
  logic [FILL_W-1:0] fill, fill_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [FILL_W-1:0] last_cut, last_cut_next;
  logic [FILL_W-1:0] cnt, cnt_next;
  logic              item_op;
  logic              item_brk;
  logic [BYTE_W-1:0] item_byte;
  logic [BYTE_W-1:0] rd_data;

  logic [LW_W-1:0]   eff_width;
  logic [FILL_W-1:0] cut;
  logic [SUM_W-1:0]  tail_sum;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  head_inc;
  logic              we;
  logic [BYTE_W-1:0] wdata;

  always_comb begin
    if (line_width == '0) begin
      eff_width = LW_W'(1);
    end else if (CMP_W'(line_width) > CMP_W'(MAX_WIDTH)) begin
      eff_width = LW_W'(MAX_WIDTH);
    end else begin
      eff_width = line_width;
    end
  end

  assign cut = (break_at_space && (last_cut != '0)) ? last_cut : fill;

  assign tail_sum = SUM_W'(head) + SUM_W'(fill);
  assign tail     = (tail_sum >= SUM_W'(MAX_WIDTH)) ? PTR_W'(tail_sum - SUM_W'(MAX_WIDTH))
                                                     : PTR_W'(tail_sum);
  assign head_inc = (head == PTR_W'(MAX_WIDTH - 1)) ? '0 : head + PTR_W'(1);

  assign st.flush     = (op == OP_FLUSH) || (in_byte == NEWLINE_BYTE);
  assign st.in_nl     = (op == OP_DATA);
  assign st.fill_zero = (fill == '0);
  assign st.brk       = !st.flush && (CMP_W'(fill) >= CMP_W'(eff_width));
  assign st.out_free  = !out_valid || out_ready;
  assign st.cnt_one   = (cnt == FILL_W'(1));
  assign st.item_nl   = (item_op == OP_DATA);

  always_comb begin
    fill_next     = fill;
    head_next     = head;
    last_cut_next = last_cut;
    cnt_next      = cnt;
    we            = 1'b0;
    wdata         = in_byte;
    if (cmd.take) begin
      if (st.flush) begin
        cnt_next      = fill;
        last_cut_next = '0;
      end else if (st.brk) begin
        cnt_next      = cut;
        last_cut_next = '0;
      end else begin
        we = 1'b1;
      end
    end
    if (cmd.ld_byte) begin
      head_next = head_inc;
      fill_next = fill - FILL_W'(1);
      cnt_next  = cnt - FILL_W'(1);
    end
    if (cmd.ld_nl && item_brk) begin
      we    = 1'b1;
      wdata = item_byte;
    end
    if (we) begin
      fill_next = fill + FILL_W'(1);
      if (is_blank(wdata)) begin
        last_cut_next = fill + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[tail] <= wdata;
    end
    if (cmd.rd) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    if (cmd.take) begin
      item_op   <= op;
      item_byte <= in_byte;
      item_brk  <= st.brk;
    end
    if (cmd.ld_byte) begin
      out_byte <= rd_data;
      run_end  <= st.cnt_one && (item_op == OP_FLUSH);
    end else if (cmd.ld_nl) begin
      out_byte <= NEWLINE_BYTE;
      run_end  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill           <= '0;
      head           <= '0;
      last_cut       <= '0;
      out_valid      <= 1'b0;
      line_width     <= LINE_WIDTH_RST;
      break_at_space <= 1'b0;
    end else begin
      fill     <= fill_next;
      head     <= head_next;
      last_cut <= last_cut_next;
      if (cmd.ld_byte || cmd.ld_nl) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_WIDTH:     line_width     <= cfg_data;
          REG_BREAK_AT_SPACE: break_at_space <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/text_line_folder_core.sv =====
// ----------------------------------------------------------------------------
// text_line_folder_core
// Folds a byte stream into lines of at most line_width bytes, with line_width clamped to 1..MAX_WIDTH.
// ----------------------------------------------------------------------------
// A data byte that causes no break is written to the segment ring and yields
// no beat. An item that emits pending bytes reads each from the segment ring
// and loads it into the output register, stalling while that register holds
// an untaken beat, then loads the newline when one follows.
// The output register lets the next item be taken while the last beat waits.
// Configuration registers: index 0 line_width, index 1 break_at_space.
`default_nettype none

module text_line_folder_core #(
  parameter int MAX_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tlf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tlf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            op,
  input  wire logic [tlf_pkg::BYTE_W-1:0]      in_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [tlf_pkg::BYTE_W-1:0]           out_byte,
  output logic                                 run_end
);
  import tlf_pkg::*;

  tlf_cmd_t    cmd;
  tlf_status_t st;

  assign cfg_ready = 1'b1;

  tlf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tlf_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .in_byte   (in_byte),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_end   (run_end)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for text_line_folder_core: a scoreboard class keeps its own copy
// of the pending segment and both registers, predicts the bytes each accepted
// beat causes, and checks every output beat in order. A short directed part
// is followed by random text-like traffic over several register settings,
// with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tlf_pkg::*;

  localparam int SEG_DEPTH = 32;

  class line_fold_scoreboard;
    typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
    } fold_beat_t;

    fold_beat_t        pending_beats[$];
    logic [BYTE_W-1:0] seg[SEG_DEPTH];
    int unsigned       fill;
    logic [LW_W-1:0]   width_reg;
    logic              space_mode;
    int                errors;

    function new();
      fill = 0;
      width_reg = LINE_WIDTH_RST;
      space_mode = 1'b0;
      errors = 0;
    endfunction

    function void report(string msg);
      if (errors < 100) $display("tb_top: error at %0t: %s", $time, msg);
      errors++;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_LINE_WIDTH) width_reg = data;
      else if (idx == REG_BREAK_AT_SPACE) space_mode = data[0];
    endfunction

    function bit is_ws(logic [BYTE_W-1:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    // work out the bytes one accepted input beat causes
    function void note_input(logic item_op, logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] emitted[$];
      int unsigned       eff;
      int unsigned       cut;
      fold_beat_t        nb;
      if (item_op == OP_FLUSH || b == NEWLINE_BYTE) begin
        for (int i = 0; i < fill; i++) emitted.push_back(seg[i]);
        fill = 0;
        if (item_op == OP_DATA) emitted.push_back(NEWLINE_BYTE);
      end else begin
        eff = (width_reg == 0) ? 1 : (width_reg > SEG_DEPTH) ? SEG_DEPTH : width_reg;
        if (fill >= eff) begin
          cut = fill;
          if (space_mode) begin
            for (int k = fill; k > 0; k--) begin
              if (is_ws(seg[k-1])) begin
                cut = k;
                break;
              end
            end
          end
          for (int i = 0; i < cut; i++) emitted.push_back(seg[i]);
          emitted.push_back(NEWLINE_BYTE);
          for (int i = 0; i < fill - cut; i++) seg[i] = seg[i + cut];
          fill -= cut;
        end
        if (fill < SEG_DEPTH) begin
          seg[fill] = b;
          fill++;
        end
      end
      foreach (emitted[i]) begin
        nb.data = emitted[i];
        nb.last = (i == emitted.size() - 1);
        pending_beats.push_back(nb);
      end
    endfunction

    function void check_beat(logic [BYTE_W-1:0] b, logic last);
      fold_beat_t exp_beat;
      if (pending_beats.size() == 0) begin
        report($sformatf("unexpected beat out_byte %02h run_end %0b", b, last));
      end else begin
        exp_beat = pending_beats.pop_front();
        if (b !== exp_beat.data)
          report($sformatf("out_byte %02h, predicted %02h", b, exp_beat.data));
        if (last !== exp_beat.last)
          report($sformatf("run_end %0b, predicted %0b", last, exp_beat.last));
      end
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_LINE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   op = OP_DATA;
  logic [BYTE_W-1:0]      in_byte = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [BYTE_W-1:0]      out_byte;
  logic                   run_end;

  int unsigned send_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  line_fold_scoreboard sb;

  text_line_folder_core #(
    .MAX_WIDTH(SEG_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .run_end(run_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_beat(out_byte, run_end);
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic set_fold(input int unsigned width, input logic space);
    write_cfg(REG_LINE_WIDTH, width[CFG_DATA_W-1:0]);
    write_cfg(REG_BREAK_AT_SPACE, {5'($urandom_range(31)), space});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic item_op, input logic [BYTE_W-1:0] item_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= item_op;
    in_byte  <= item_byte;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item_op, item_byte);
  endtask

  // pause the sender until every predicted beat is out, then let the core settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_item(output logic item_op, output logic [BYTE_W-1:0] b);
    int unsigned r;
    r = $urandom_range(99);
    item_op = OP_DATA;
    if (r < 3) begin
      item_op = OP_FLUSH;
      b = 8'($urandom_range(255));
    end else if (r < 10) begin
      b = NEWLINE_BYTE;
    end else if (r < 25) begin
      b = $urandom_range(1) ? 8'h20 : 8'($urandom_range(8'h0D, 8'h09));
    end else if (r < 35) begin
      b = 8'($urandom_range(255));
    end else begin
      b = 8'($urandom_range(8'h7A, 8'h61));
    end
  endtask

  initial begin
    int unsigned       widths[8];
    logic              spaces[8];
    logic              item_op;
    logic [BYTE_W-1:0] b;

    widths = '{32, 63, 3, 0, 12, 1, 0, 7};
    spaces = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    sb = new();
    send_idle_pct = 37;
    rcv_idle_pct = 53;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // register defaults
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_FLUSH, 8'hA5);
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_DATA, NEWLINE_BYTE);
    wait_drained();

    // narrow lines, break after whitespace
    set_fold(4, 1'b1);
    send_item(OP_DATA, 8'h61);
    send_item(OP_DATA, 8'h62);
    send_item(OP_DATA, 8'h20);
    send_item(OP_DATA, 8'h63);
    send_item(OP_DATA, 8'h64);
    send_item(OP_DATA, 8'h09);
    send_item(OP_DATA, 8'h0D);
    send_item(OP_DATA, 8'h0E);
    send_item(OP_DATA, 8'h08);
    send_item(OP_DATA, 8'h0B);
    send_item(OP_DATA, 8'h0C);
    send_item(OP_DATA, 8'h21);
    send_item(OP_DATA, NEWLINE_BYTE);
    send_item(OP_DATA, 8'h7A);
    send_item(OP_DATA, 8'h7B);
    send_item(OP_DATA, 8'h7C);
    wait_drained();

    // width zero with a longer segment still pending
    set_fold(0, 1'b0);
    send_item(OP_DATA, 8'h7D);
    send_item(OP_FLUSH, 8'hFF);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      set_fold((ph == 6) ? $urandom_range(63) : widths[ph], spaces[ph]);
      if (ph < 3) begin
        send_idle_pct = 37;
        rcv_idle_pct = 53;
      end else if (ph < 6) begin
        send_idle_pct = 53;
        rcv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      for (int n = 0; n < 60; n++) begin
        random_item(item_op, b);
        send_item(item_op, b);
      end
    end
    send_item(OP_FLUSH, 8'h00);
    wait_drained();
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tlf_pkg.sv
rtl/tlf_ctrl.sv
rtl/tlf_datapath.sv
rtl/text_line_folder_core.sv
tb/sv/tb_top.sv
